### hw/rtl/akv_pkg.sv
package akv_pkg;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;

    localparam int WORD_W      = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int KEY_W       = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;
    localparam int VAL_W       = (VALUE_BITS < WORD_W) ? VALUE_BITS : WORD_W;
    localparam int COUNT_W     = $clog2(ENTRIES + 1);

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VAL_W-1:0]   val_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } akv_op_t;

    typedef enum logic {
        AKV_IDLE = 1'b0,
        AKV_EXEC = 1'b1
    } akv_state_t;

    typedef struct packed {
        logic look;
        key_t ckey;
        logic upd;
        logic app;
        logic rem;
        key_t wkey;
        val_t wval;
    } akv_cell_ctl_t;

endpackage

### hw/rtl/akv_cell.sv
module akv_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  akv_pkg::akv_cell_ctl_t ctl,
    input  logic                   valid,
    input  logic                   tail,
    input  logic                   shift_in,
    input  akv_pkg::key_t          nb_key,
    input  akv_pkg::val_t          nb_value,
    output akv_pkg::key_t          key,
    output akv_pkg::val_t          value,
    output logic                   hit,
    output logic                   shift_out
);
    import akv_pkg::*;

    key_t key_reg;
    key_t key_next;
    val_t value_reg;
    val_t value_next;
    logic hit_reg;
    logic hit_next;

    assign shift_out = shift_in | hit_reg;
    assign key       = key_reg;
    assign value     = value_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.look)
        begin
            hit_next = valid && (key_reg == ctl.ckey);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (ctl.rem && shift_out)
        begin
            key_next   = nb_key;
            value_next = nb_value;
        end
        else if (ctl.upd && hit_reg)
        begin
            value_next = ctl.wval;
        end
        else if (ctl.app && tail)
        begin
            key_next   = ctl.wkey;
            value_next = ctl.wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

### hw/rtl/associative_key_value_table_core.sv
// channel | valid     | stall     | fields
// request | req_valid | req_stall | op, key, value
// result  | rsp_valid | rsp_stall | ok, value_out, entry_count
//
// For each operation, the accept edge compares the key in every cell, and then
// the execute edge updates the cell row and loads the result register.
// Execute waits while a held result is stalled; no new request is taken meanwhile.
// Reset clears the entry count; cell contents are never read until written.
module associative_key_value_table_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        op,
    input  logic [akv_pkg::WORD_W-1:0]        key,
    input  logic [akv_pkg::WORD_W-1:0]        value,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              ok,
    output logic [akv_pkg::WORD_W-1:0]        value_out,
    output logic [akv_pkg::COUNT_OUT_W-1:0]   entry_count
);
    import akv_pkg::*;

    akv_state_t    state_reg;
    akv_state_t    state_next;
    logic          accept;
    logic          exec_go;

    akv_op_t       op_reg;
    key_t          wkey_reg;
    val_t          wval_reg;
    count_t        count_reg;
    count_t        count_next;

    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    logic          ok_reg;
    logic          ok_next;
    logic [WORD_W-1:0]      value_out_reg;
    logic [WORD_W-1:0]      value_out_next;
    logic [COUNT_OUT_W-1:0] entry_count_reg;

    akv_cell_ctl_t ctl;
    logic [ENTRIES-1:0] hits;
    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] cell_tail;
    logic [ENTRIES:0]   shift_chain;
    key_t               cell_key [ENTRIES];
    val_t               cell_value [ENTRIES];
    logic               any_hit;
    logic               full;
    val_t               sel_value;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AKV_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = AKV_EXEC;
                end
            end
            AKV_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = AKV_IDLE;
                end
            end
            default:
            begin
                state_next = AKV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        exec_go   = 1'b0;
        unique case (state_reg)
            AKV_IDLE:
            begin
                req_stall = 1'b0;
            end
            AKV_EXEC:
            begin
                exec_go = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;
    assign any_hit = |hits;
    assign full    = (count_reg == COUNT_W'(ENTRIES));

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sel_value = sel_value | (cell_value[i] & {VAL_W{hits[i]}});
        end
    end

    always_comb
    begin
        ctl.look = accept;
        ctl.ckey = KEY_W'(key);
        ctl.upd  = exec_go && (op_reg == OP_ADD) && !full && any_hit;
        ctl.app  = exec_go && (op_reg == OP_ADD) && !full && !any_hit;
        ctl.rem  = exec_go && (op_reg == OP_REMOVE) && any_hit;
        ctl.wkey = wkey_reg;
        ctl.wval = wval_reg;
    end

    assign shift_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        key_t nb_key;
        val_t nb_value;

        assign cell_valid[g] = (COUNT_W'(g) < count_reg);
        assign cell_tail[g]  = (COUNT_W'(g) == count_reg);

        if (g == ENTRIES - 1)
        begin : g_last
            assign nb_key   = cell_key[g];
            assign nb_value = cell_value[g];
        end
        else
        begin : g_mid
            assign nb_key   = cell_key[g+1];
            assign nb_value = cell_value[g+1];
        end

        akv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .valid     (cell_valid[g]),
            .tail      (cell_tail[g]),
            .shift_in  (shift_chain[g]),
            .nb_key    (nb_key),
            .nb_value  (nb_value),
            .key       (cell_key[g]),
            .value     (cell_value[g]),
            .hit       (hits[g]),
            .shift_out (shift_chain[g+1])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        ok_next        = 1'b0;
        value_out_next = '0;
        unique case (op_reg)
            OP_ADD:
            begin
                ok_next = !full;
                if (!full && !any_hit)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_GET:
            begin
                ok_next = any_hit;
                if (any_hit)
                begin
                    value_out_next = WORD_W'(sel_value);
                end
            end
            OP_REMOVE:
            begin
                ok_next = any_hit;
                if (any_hit)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                ok_next    = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign rsp_valid_next = exec_go || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= AKV_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    // hold the request for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= akv_op_t'(op);
            wkey_reg <= KEY_W'(key);
            wval_reg <= VAL_W'(value);
        end
        if (exec_go)
        begin
            ok_reg          <= ok_next;
            value_out_reg   <= value_out_next;
            entry_count_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = ok_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;

endmodule

### hw/rtl/akv_checker.sv
module akv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_stall,
    input logic [1:0]                        op,
    input logic [akv_pkg::WORD_W-1:0]        key,
    input logic [akv_pkg::WORD_W-1:0]        value,
    input logic                              rsp_valid,
    input logic                              rsp_stall,
    input logic                              ok,
    input logic [akv_pkg::WORD_W-1:0]        value_out,
    input logic [akv_pkg::COUNT_OUT_W-1:0]   entry_count
);
    import akv_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(ok) && $stable(value_out)
            && $stable(entry_count))
        else $error("stalled result beat changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (entry_count <= COUNT_OUT_W'(ENTRIES)))
        else $error("entry count above table size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one executes");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> (value_out == '0))
        else $error("value returned on failed operation");

endmodule

bind associative_key_value_table_core akv_checker u_akv_checker (.*);

### tb/akv_table_checker.sv
module akv_table_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic [1:0]                      op,
    input  logic [akv_pkg::WORD_W-1:0]      key,
    input  logic [akv_pkg::WORD_W-1:0]      value,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  logic                            ok,
    input  logic [akv_pkg::WORD_W-1:0]      value_out,
    input  logic [akv_pkg::COUNT_OUT_W-1:0] entry_count,
    output int                              mismatch_count,
    output int                              replies_pending,
    output int                              full_refusals
);
    import akv_pkg::*;

    typedef struct {
        logic                   ok;
        logic [WORD_W-1:0]      value_out;
        logic [COUNT_OUT_W-1:0] entry_count;
    } table_reply_t;

    key_t         stored_keys [ENTRIES];
    val_t         stored_vals [ENTRIES];
    int           live_entries;
    table_reply_t replies_due [$];
    table_reply_t want;

    function automatic int slot_of(key_t k);
        for (int i = 0; i < live_entries; i++)
        begin
            if (stored_keys[i] == k)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic table_reply_t table_step(akv_op_t o, key_t k, val_t v);
        table_reply_t r;
        int           slot;
        r.ok        = 1'b0;
        r.value_out = '0;
        case (o)
            OP_ADD:
            begin
                if (live_entries < ENTRIES)
                begin
                    slot = slot_of(k);
                    if (slot >= 0)
                    begin
                        stored_vals[slot] = v;
                    end
                    else
                    begin
                        stored_keys[live_entries] = k;
                        stored_vals[live_entries] = v;
                        live_entries++;
                    end
                    r.ok = 1'b1;
                end
                else
                begin
                    full_refusals++;
                end
            end
            OP_GET:
            begin
                slot = slot_of(k);
                if (slot >= 0)
                begin
                    r.ok        = 1'b1;
                    r.value_out = WORD_W'(stored_vals[slot]);
                end
            end
            OP_REMOVE:
            begin
                slot = slot_of(k);
                if (slot >= 0)
                begin
                    // close the gap, keep insertion order
                    for (int j = slot; j + 1 < live_entries; j++)
                    begin
                        stored_keys[j] = stored_keys[j + 1];
                        stored_vals[j] = stored_vals[j + 1];
                    end
                    live_entries--;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                live_entries = 0;
                r.ok         = 1'b1;
            end
        endcase
        r.entry_count = COUNT_OUT_W'(live_entries);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_entries = 0;
            replies_due.delete();
            mismatch_count = 0;
            full_refusals  = 0;
            replies_pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0b, actual %0b", want.ok, ok);
                        mismatch_count++;
                    end
                    if (value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, actual %h", want.value_out, value_out);
                        mismatch_count++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                replies_due.push_back(table_step(akv_op_t'(op), key_t'(key), val_t'(value)));
            end
            replies_pending <= replies_due.size();
        end
    end

endmodule

### tb/tb_associative_key_value_table_core.sv
module tb_associative_key_value_table_core;
    import akv_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 24;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    logic [1:0]             op;
    logic [WORD_W-1:0]      key;
    logic [WORD_W-1:0]      value;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic                   ok;
    logic [WORD_W-1:0]      value_out;
    logic [COUNT_OUT_W-1:0] entry_count;

    int                     mismatch_count;
    int                     replies_pending;
    int                     full_refusals;
    int                     op_tally [4];
    int                     idle_cycles;
    int unsigned            rsp_hold;
    bit                     quiet;
    logic [WORD_W-1:0]      key_pool [POOL_SIZE];

    associative_key_value_table_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .ok          (ok),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    akv_table_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .op              (op),
        .key             (key),
        .value           (value),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .ok              (ok),
        .value_out       (value_out),
        .entry_count     (entry_count),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending),
        .full_refusals   (full_refusals)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hold the result channel for a drawn number of cycles after each beat
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            rsp_hold = quiet ? 0 : $urandom_range(0, 3);
        end
        else if (rsp_hold != 0)
        begin
            rsp_hold--;
        end
        rsp_stall <= (rsp_hold != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input akv_op_t o, input logic [WORD_W-1:0] k,
                             input logic [WORD_W-1:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= o;
        key       <= k;
        value     <= v;
        do
            @(posedge clk);
        while (req_stall);
        op_tally[o]++;
    endtask

    function automatic logic [WORD_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
        begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic akv_op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 46)
        begin
            return OP_ADD;
        end
        if (r < 72)
        begin
            return OP_GET;
        end
        if (r < 97)
        begin
            return OP_REMOVE;
        end
        return OP_CLEAR;
    endfunction

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        op        <= OP_ADD;
        key       <= '0;
        value     <= '0;
        quiet      = 1'b0;
        rsp_hold   = 0;
        foreach (op_tally[i])
        begin
            op_tally[i] = 0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        key_pool[4] = $urandom;
        // near neighbours: one bit away from a common base
        for (int i = 5; i < 13; i++)
        begin
            key_pool[i] = key_pool[4] ^ (32'h1 << $urandom_range(0, 31));
        end
        for (int i = 13; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(OP_CLEAR,  '0, '0);
        send_beat(OP_GET,    '0, '1);
        send_beat(OP_REMOVE, '0, '0);
        send_beat(OP_ADD,    '0, '1);
        send_beat(OP_ADD,    '1, '0);
        send_beat(OP_GET,    '1, '1);
        send_beat(OP_ADD,    '0, 32'h1234_5678);
        send_beat(OP_GET,    '0, '0);
        for (int i = 0; i < ENTRIES - 2; i++)
        begin
            send_beat(OP_ADD, 32'h1000_0000 + i, $urandom);
        end
        // full table refuses an update and a new key alike
        send_beat(OP_ADD,    '0, 32'hDEAD_BEEF);
        send_beat(OP_ADD,    32'h7777_7777, 32'h1);
        send_beat(OP_REMOVE, 32'h1000_0005, '0);
        send_beat(OP_GET,    32'h1000_0000 + ENTRIES - 3, '0);
        send_beat(OP_CLEAR,  '1, '1);
        send_beat(OP_GET,    '1, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = ((n / 50) % 4) == 3;
            send_beat(pick_op(), pick_key(), pick_value());
        end
        quiet = 1'b0;
        req_valid <= 1'b0;
        @(posedge clk);

        while (replies_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Covered %0d requests: %0d add, %0d get, %0d remove, %0d clear",
                 op_tally[OP_ADD] + op_tally[OP_GET] + op_tally[OP_REMOVE] + op_tally[OP_CLEAR],
                 op_tally[OP_ADD], op_tally[OP_GET], op_tally[OP_REMOVE], op_tally[OP_CLEAR]);
        $display("Adds refused on a full table: %0d", full_refusals);
        if (mismatch_count == 0 && replies_pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/akv_pkg.sv
hw/rtl/akv_cell.sv
hw/rtl/associative_key_value_table_core.sv
hw/rtl/akv_checker.sv
tb/akv_table_checker.sv
tb/tb_associative_key_value_table_core.sv
